// ----- rtl/core/mep_pkg.sv -----
`default_nettype none

package mep_pkg;

  // Coordinate and fixed-point format (Q8.FRAC_BITS)
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int FIX_W      = FRAC_BITS + 8;
  localparam int MAG_W      = FRAC_BITS + 3;   // magnitude up to 4.0
  localparam int SQ_W       = FRAC_BITS + 5;   // truncated square up to 16.0
  localparam int EXT_W      = FIX_W + 2;       // headroom for update sums

  // Pixel-to-point mapping
  localparam int CENTER_W   = 16;
  localparam int STEP_W     = 32;
  localparam int DIFF_W     = CENTER_W + 1;
  localparam int PROD_W     = DIFF_W + STEP_W;
  localparam int STEP_SHIFT = STEP_W - FRAC_BITS;
  localparam int PM_W       = PROD_W - STEP_SHIFT;

  // Output widths
  localparam int ITER_W     = 9;
  localparam int COLOR_W    = 8;

  // Queue between front and back
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 2'd2;
  localparam logic [STEP_W-1:0]    STEP_RESET     = 32'd16777216;

  typedef logic [FIX_W-1:0] fix_t;

  localparam fix_t FIX_MAX  = {1'b0, {(FIX_W-1){1'b1}}};
  localparam fix_t FIX_MIN  = {1'b1, {(FIX_W-1){1'b0}}};
  localparam fix_t FIX_FOUR = FIX_W'(4) << FRAC_BITS;
  localparam logic [SQ_W:0] FIX_SIXTEEN = (SQ_W+1)'(16) << FRAC_BITS;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [ITER_W-1:0]  iterations;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_out_t;

  typedef struct packed {
    fix_t cr;
    fix_t ci;
  } point_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [STEP_W-1:0]   pixel_step;
  } map_cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_UPDATE,
    BK_DONE
  } back_state_t;

  // Clamp a widened sum back into the Q8 range
  function automatic fix_t sat_fix(input logic [EXT_W-1:0] v);
    logic over;
    over = (v[EXT_W-1:FIX_W-1] != {(EXT_W-FIX_W+1){1'b0}}) &&
           (v[EXT_W-1:FIX_W-1] != {(EXT_W-FIX_W+1){1'b1}});
    if (!over) begin
      sat_fix = v[FIX_W-1:0];
    end else if (v[EXT_W-1]) begin
      sat_fix = FIX_MIN;
    end else begin
      sat_fix = FIX_MAX;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mep_front.sv -----
`default_nettype none

module mep_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mep_pkg::pixel_in_t in_data,
  input  wire mep_pkg::map_cfg_t  cfg,
  output logic                    push,
  output mep_pkg::point_t         push_data,
  input  wire logic               q_full
);

  logic                             s1_v_r, s1_v_nxt;
  logic                             s2_v_r, s2_v_nxt;
  logic                             s1_ready, s2_ready;
  logic [mep_pkg::DIFF_W-1:0]       dx, dy;
  logic [mep_pkg::DIFF_W-1:0]       mag_x_r, mag_y_r;
  logic                             neg_x_r, neg_y_r;
  logic [mep_pkg::PROD_W-1:0]       prod_x_r, prod_y_r;
  logic                             pneg_x_r, pneg_y_r;

  function automatic mep_pkg::fix_t map_sat(input logic [mep_pkg::PROD_W-1:0] p,
                                            input logic neg);
    logic [mep_pkg::PM_W-1:0] m;
    logic                     big;
    m   = mep_pkg::PM_W'(p >> mep_pkg::STEP_SHIFT);
    big = |m[mep_pkg::PM_W-1:mep_pkg::FIX_W-1];
    if (neg) begin
      map_sat = big ? mep_pkg::FIX_MIN : mep_pkg::FIX_W'(0) - m[mep_pkg::FIX_W-1:0];
    end else begin
      map_sat = big ? mep_pkg::FIX_MAX : m[mep_pkg::FIX_W-1:0];
    end
  endfunction

  assign s2_ready = !s2_v_r || !q_full;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_stall = !s1_ready;
  assign push     = s2_v_r && !q_full;

  assign push_data.cr = map_sat(prod_x_r, pneg_x_r);
  assign push_data.ci = map_sat(prod_y_r, pneg_y_r);

  assign dx = {{(mep_pkg::DIFF_W-mep_pkg::COORD_BITS){1'b0}}, in_data.pixel_x}
            - {cfg.center_x[mep_pkg::CENTER_W-1], cfg.center_x};
  assign dy = {{(mep_pkg::DIFF_W-mep_pkg::COORD_BITS){1'b0}}, in_data.pixel_y}
            - {cfg.center_y[mep_pkg::CENTER_W-1], cfg.center_y};

  always_comb begin
    s1_v_nxt = s1_v_r;
    s2_v_nxt = s2_v_r;
    if (s1_ready) begin
      s1_v_nxt = in_valid;
    end
    if (s2_ready) begin
      s2_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Stage 1: offset from center, split into sign and magnitude
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      neg_x_r <= dx[mep_pkg::DIFF_W-1];
      neg_y_r <= dy[mep_pkg::DIFF_W-1];
      mag_x_r <= dx[mep_pkg::DIFF_W-1] ? mep_pkg::DIFF_W'(0) - dx : dx;
      mag_y_r <= dy[mep_pkg::DIFF_W-1] ? mep_pkg::DIFF_W'(0) - dy : dy;
    end
  end

  // Stage 2: scale by the pixel step
  always_ff @(posedge clk) begin
    if (s2_ready) begin
      prod_x_r <= mep_pkg::PROD_W'(mag_x_r) * mep_pkg::PROD_W'(cfg.pixel_step);
      prod_y_r <= mep_pkg::PROD_W'(mag_y_r) * mep_pkg::PROD_W'(cfg.pixel_step);
      pneg_x_r <= neg_x_r;
      pneg_y_r <= neg_y_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mep_queue.sv -----
`default_nettype none

module mep_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mep_pkg::point_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output mep_pkg::point_t      pop_data,
  output logic                 empty
);

  mep_pkg::point_t                ent_r [mep_pkg::Q_DEPTH];
  logic [mep_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mep_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mep_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == mep_pkg::Q_CNT_W'(mep_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mep_back.sv -----
`default_nettype none

module mep_back #(
  parameter int MAX_ITER = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire mep_pkg::point_t q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output mep_pkg::pixel_out_t  out_data
);

  localparam int CNT_W = $clog2(MAX_ITER + 1);
  localparam int SX_W  = (CNT_W > mep_pkg::ITER_W) ? CNT_W : mep_pkg::ITER_W;

  mep_pkg::back_state_t          state_r, state_nxt;
  mep_pkg::fix_t                 cr_r, cr_nxt, ci_r, ci_nxt;
  mep_pkg::fix_t                 zr_r, zr_nxt, zi_r, zi_nxt;
  logic [CNT_W-1:0]              steps_r, steps_nxt;
  logic [mep_pkg::SQ_W-1:0]      sr_r, sr_nxt, si_r, si_nxt, pm_r, pm_nxt;
  logic                          pneg_r, pneg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  mep_pkg::pixel_out_t           out_data_r, out_data_nxt;

  mep_pkg::fix_t                 mag_r, mag_i;
  logic [mep_pkg::MAG_W-1:0]     ma, mb;
  logic [2*mep_pkg::MAG_W-1:0]   p_rr, p_ii, p_ri;
  logic [mep_pkg::SQ_W:0]        sum_sq;
  logic [mep_pkg::EXT_W-1:0]     sr_x, si_x, p2_x, p2_s, cr_x, ci_x;
  logic [SX_W-1:0]               steps_x;
  logic [mep_pkg::COLOR_W-1:0]   k, kx2, kx4;
  logic                          out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Square stage operands
  assign mag_r = zr_r[mep_pkg::FIX_W-1] ? mep_pkg::FIX_W'(0) - zr_r : zr_r;
  assign mag_i = zi_r[mep_pkg::FIX_W-1] ? mep_pkg::FIX_W'(0) - zi_r : zi_r;
  assign ma    = mag_r[mep_pkg::MAG_W-1:0];
  assign mb    = mag_i[mep_pkg::MAG_W-1:0];
  assign p_rr  = (2*mep_pkg::MAG_W)'(ma) * (2*mep_pkg::MAG_W)'(ma);
  assign p_ii  = (2*mep_pkg::MAG_W)'(mb) * (2*mep_pkg::MAG_W)'(mb);
  assign p_ri  = (2*mep_pkg::MAG_W)'(ma) * (2*mep_pkg::MAG_W)'(mb);

  // Update stage operands
  assign sum_sq = {1'b0, sr_r} + {1'b0, si_r};
  assign sr_x   = mep_pkg::EXT_W'(sr_r);
  assign si_x   = mep_pkg::EXT_W'(si_r);
  assign p2_x   = {{(mep_pkg::EXT_W-mep_pkg::SQ_W-1){1'b0}}, pm_r, 1'b0};
  assign p2_s   = pneg_r ? mep_pkg::EXT_W'(0) - p2_x : p2_x;
  assign cr_x   = {{(mep_pkg::EXT_W-mep_pkg::FIX_W){cr_r[mep_pkg::FIX_W-1]}}, cr_r};
  assign ci_x   = {{(mep_pkg::EXT_W-mep_pkg::FIX_W){ci_r[mep_pkg::FIX_W-1]}}, ci_r};

  // Color from k = 256 - steps, all mod 256
  assign steps_x = SX_W'(steps_r);
  assign k       = mep_pkg::COLOR_W'(0) - steps_x[mep_pkg::COLOR_W-1:0];
  assign kx2     = {k[mep_pkg::COLOR_W-2:0], 1'b0};
  assign kx4     = {k[mep_pkg::COLOR_W-3:0], 2'b00};

  always_comb begin
    state_nxt     = state_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    steps_nxt     = steps_r;
    sr_nxt        = sr_r;
    si_nxt        = si_r;
    pm_nxt        = pm_r;
    pneg_nxt      = pneg_r;
    pop           = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      mep_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          cr_nxt    = q_data.cr;
          ci_nxt    = q_data.ci;
          zr_nxt    = '0;
          zi_nxt    = '0;
          steps_nxt = '0;
          state_nxt = mep_pkg::BK_SQUARE;
        end
      end
      mep_pkg::BK_SQUARE: begin
        if (steps_r == CNT_W'(MAX_ITER) ||
            mag_r > mep_pkg::FIX_FOUR || mag_i > mep_pkg::FIX_FOUR) begin
          state_nxt = mep_pkg::BK_DONE;
        end else begin
          sr_nxt    = mep_pkg::SQ_W'(p_rr >> mep_pkg::FRAC_BITS);
          si_nxt    = mep_pkg::SQ_W'(p_ii >> mep_pkg::FRAC_BITS);
          pm_nxt    = mep_pkg::SQ_W'(p_ri >> mep_pkg::FRAC_BITS);
          pneg_nxt  = zr_r[mep_pkg::FIX_W-1] ^ zi_r[mep_pkg::FIX_W-1];
          state_nxt = mep_pkg::BK_UPDATE;
        end
      end
      mep_pkg::BK_UPDATE: begin
        if (sum_sq > mep_pkg::FIX_SIXTEEN) begin
          state_nxt = mep_pkg::BK_DONE;
        end else begin
          zr_nxt    = mep_pkg::sat_fix(sr_x - si_x + cr_x);
          zi_nxt    = mep_pkg::sat_fix(p2_s + ci_x);
          steps_nxt = steps_r + 1'b1;
          state_nxt = mep_pkg::BK_SQUARE;
        end
      end
      mep_pkg::BK_DONE: begin
        // hold until the output register can take the item
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.iterations = steps_x[mep_pkg::ITER_W-1:0];
          out_data_nxt.red        = kx4;
          out_data_nxt.green      = kx4 + kx2;
          out_data_nxt.blue       = {k[mep_pkg::COLOR_W-4:0], 3'b000};
          state_nxt               = mep_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = mep_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mep_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr_r       <= cr_nxt;
    ci_r       <= ci_nxt;
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    steps_r    <= steps_nxt;
    sr_r       <= sr_nxt;
    si_r       <= si_nxt;
    pm_r       <= pm_nxt;
    pneg_r     <= pneg_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/mandelbrot_escape_pixel.sv -----
// Escape-time evaluator: one pixel in, iteration count and color out.
// Pixels pass the front stages (offset, scale) and a queue; the back end
// loops square, then add-and-compare, until the step limit, |zr| or |zi|
// above 4.0, or zr^2 + zi^2 above 16.0; it takes one pixel at a time.
// Reset: synchronous, active low; clears pipeline, queue and output valid,
// and sets center_x = 0, center_y = 0, pixel_step = 2^24.
`default_nettype none

module mandelbrot_escape_pixel #(
  parameter int MAX_ITER = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire mep_pkg::pixel_in_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output mep_pkg::pixel_out_t                    out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [mep_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mep_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  mep_pkg::map_cfg_t cfg_r, cfg_nxt;
  mep_pkg::point_t   push_data, pop_data;
  logic              push, pop, q_full, q_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        mep_pkg::CFG_CENTER_X:   cfg_nxt.center_x   = cfg_wdata[mep_pkg::CENTER_W-1:0];
        mep_pkg::CFG_CENTER_Y:   cfg_nxt.center_y   = cfg_wdata[mep_pkg::CENTER_W-1:0];
        mep_pkg::CFG_PIXEL_STEP: cfg_nxt.pixel_step = cfg_wdata[mep_pkg::STEP_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x   <= '0;
      cfg_r.center_y   <= '0;
      cfg_r.pixel_step <= mep_pkg::STEP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  mep_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  mep_back #(
    .MAX_ITER (MAX_ITER)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/mep_checker.sv -----
`default_nettype none

module mep_checker #(
  parameter int MAX_ITER = 256
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire mep_pkg::pixel_in_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire mep_pkg::pixel_out_t out_data
);

  logic [7:0] k_chk;

  assign k_chk = 8'd0 - out_data.iterations[7:0];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Colors follow k = 256 - iterations
  a_colors: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.red   == 8'(k_chk * 8'd4) &&
      out_data.green == 8'(k_chk * 8'd6) &&
      out_data.blue  == 8'(k_chk * 8'd8))
    else $error("color does not match iteration count");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // No result is shown while reset is held
  a_reset_idle: assert property (@(posedge clk)
    !rst_n ##1 !rst_n |-> !out_valid)
    else $error("result valid during reset");

  if (MAX_ITER < 512) begin : g_iter
    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_data.iterations != 9'd0 &&
                    out_data.iterations <= 9'(MAX_ITER))
      else $error("iteration count out of range");
  end

  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^in_data);

endmodule

bind mandelbrot_escape_pixel mep_checker #(
  .MAX_ITER (MAX_ITER)
) u_mep_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
